// ----- hdl/olid_pkg.sv -----
// shared constants, operation codes and control types for the ordered list unit
// no dependencies; used by olid_ctrl, olid_datapath and the top level
`default_nettype none

package olid_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int ELEM_W    = 32;
  localparam int IDX_W     = $clog2(MAX_DEPTH);
  localparam int LEN_W     = $clog2(MAX_DEPTH + 1);
  localparam int OP_W      = 3;
  localparam int POS_W     = 5;
  localparam int CAP_W     = 5;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/olid_ctrl.sv -----
// controller state machine: takes one transaction, runs it, offers the result
// depends on olid_pkg
`default_nettype none

module olid_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire               m_tready,
  output olid_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_RESP);
  assign cmd.load = s_tvalid && (state == ST_IDLE);
  assign cmd.exec = (state == ST_EXEC);

endmodule

`default_nettype wire

// ----- hdl/olid_datapath.sv -----
// datapath: request registers, row of element cells with parallel shift,
// length and capacity registers, result registers; depends on olid_pkg
`default_nettype none

module olid_datapath (
  input  wire                               clk,
  input  wire                               rst,
  input  olid_pkg::ctrl_cmd_t               cmd,
  input  wire  [olid_pkg::OP_W-1:0]         operation,
  input  wire  [olid_pkg::POS_W-1:0]        position,
  input  wire  [olid_pkg::ELEM_W-1:0]       element_data,
  input  wire                               cfg_we,
  input  wire  [olid_pkg::CAP_W-1:0]        cfg_wdata,
  output logic                              accepted,
  output logic [olid_pkg::ELEM_W-1:0]       read_data,
  output logic [olid_pkg::LEN_W-1:0]        length,
  output logic                              full_res,
  output logic                              empty_res
);

  logic [olid_pkg::OP_W-1:0]   op_q;
  logic [olid_pkg::POS_W-1:0]  pos_q;
  logic [olid_pkg::ELEM_W-1:0] data_q;
  logic [olid_pkg::CAP_W-1:0]  capacity;
  logic [olid_pkg::LEN_W-1:0]  count;
  logic [olid_pkg::ELEM_W-1:0] cells [olid_pkg::MAX_DEPTH];

  logic [olid_pkg::CAP_W-1:0]  cap_eff;
  logic [olid_pkg::POS_W-1:0]  len_ext;
  logic [olid_pkg::POS_W-1:0]  ins_pos;
  logic [olid_pkg::POS_W-1:0]  last_ext;
  logic                        in_range;
  logic                        can_insert;
  logic                        do_write, do_insert, do_delete;
  logic                        ok;
  logic [olid_pkg::LEN_W-1:0]  count_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      pos_q  <= position;
      data_q <= element_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= olid_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // capacity above the store depth counts as the depth
  assign cap_eff = (capacity > olid_pkg::CAP_W'(olid_pkg::MAX_DEPTH)) ?
                   olid_pkg::CAP_W'(olid_pkg::MAX_DEPTH) : capacity;
  assign len_ext    = olid_pkg::POS_W'(count);
  assign last_ext   = len_ext - olid_pkg::POS_W'(1);
  assign in_range   = (pos_q < len_ext);
  assign can_insert = (olid_pkg::CAP_W'(count) < cap_eff);
  // insert at or past the end appends
  assign ins_pos    = (pos_q > len_ext) ? len_ext : pos_q;

  assign do_write  = cmd.exec && (op_q == olid_pkg::OP_WRITE) && in_range;
  assign do_insert = cmd.exec && (op_q == olid_pkg::OP_INSERT) && can_insert;
  assign do_delete = cmd.exec && (op_q == olid_pkg::OP_DELETE) && in_range;

  always_comb begin
    ok         = 1'b0;
    count_next = count;
    case (op_q)
      olid_pkg::OP_READ: begin
        ok = in_range;
      end
      olid_pkg::OP_WRITE: begin
        ok = in_range;
      end
      olid_pkg::OP_INSERT: begin
        ok = can_insert;
        if (can_insert) count_next = count + olid_pkg::LEN_W'(1);
      end
      olid_pkg::OP_DELETE: begin
        ok = in_range;
        if (in_range) count_next = count - olid_pkg::LEN_W'(1);
      end
      olid_pkg::OP_CLEAR: begin
        ok         = 1'b1;
        count_next = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // each cell compares its own index with the request position
  for (genvar g = 0; g < olid_pkg::MAX_DEPTH; g++) begin : g_cell
    localparam logic [olid_pkg::POS_W-1:0] IDX = olid_pkg::POS_W'(g);
    logic [olid_pkg::ELEM_W-1:0] from_below;
    logic [olid_pkg::ELEM_W-1:0] from_above;

    if (g > 0) begin : g_below
      assign from_below = cells[g-1];
    end else begin : g_no_below
      assign from_below = data_q;
    end
    if (g < olid_pkg::MAX_DEPTH - 1) begin : g_above
      assign from_above = cells[g+1];
    end else begin : g_no_above
      assign from_above = cells[g];
    end

    always_ff @(posedge clk) begin
      if (do_write && (IDX == pos_q)) begin
        cells[g] <= data_q;
      end else if (do_insert && (IDX == ins_pos)) begin
        cells[g] <= data_q;
      end else if (do_insert && (IDX > ins_pos) && (IDX <= len_ext)) begin
        cells[g] <= from_below;
      end else if (do_delete && (IDX >= pos_q) && (IDX < last_ext)) begin
        cells[g] <= from_above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      accepted  <= ok;
      read_data <= ((op_q == olid_pkg::OP_READ) && in_range) ?
                   cells[pos_q[olid_pkg::IDX_W-1:0]] : '0;
      length    <= count_next;
      full_res  <= (olid_pkg::CAP_W'(count_next) >= cap_eff);
      empty_res <= (count_next == '0);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ordered_list_insert_delete_unit.sv -----
// ordered list unit: one transaction in, one result out
// steps: request registered on accept, executed in the cell row, result held valid until taken
// a new transaction is taken only after the previous result has been taken
// reset: length cleared, capacity set to 16, element store left as is
// depends on olid_pkg, olid_ctrl, olid_datapath
`default_nettype none

module ordered_list_insert_delete_unit (
  input  wire                          clk,
  input  wire                          rst,
  // request: [2:0] operation, [7:3] position, [39:8] element_data
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [olid_pkg::IN_W-1:0]    s_tdata,
  // result: [0] accepted, [32:1] read_data, [37:33] length,
  // [38] full_res, [39] empty_res
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [olid_pkg::OUT_W-1:0]   m_tdata,
  // capacity register write
  input  wire                          cfg_we,
  input  wire  [olid_pkg::CAP_W-1:0]   cfg_wdata
);

  olid_pkg::ctrl_cmd_t cmd;

  logic                          accepted;
  logic [olid_pkg::ELEM_W-1:0]   read_data;
  logic [olid_pkg::LEN_W-1:0]    length;
  logic                          full_res;
  logic                          empty_res;

  // state machine: idle -> execute -> hold result until taken
  olid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // cell row and result registers; request fields unpacked from tdata
  olid_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (s_tdata[2:0]),
    .position     (s_tdata[7:3]),
    .element_data (s_tdata[39:8]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .accepted     (accepted),
    .read_data    (read_data),
    .length       (length),
    .full_res     (full_res),
    .empty_res    (empty_res)
  );

  // pack the result, lowest field first
  assign m_tdata = {empty_res, full_res, length, read_data, accepted};

  // one transaction in flight: never take a request while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request taken while a result is pending");

  // an accepted request passes through execute before its result shows
  a_exec_cycle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!m_tvalid && !s_tready))
    else $error("execute cycle skipped");

  // the length reported never exceeds the store depth
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (length <= olid_pkg::LEN_W'(olid_pkg::MAX_DEPTH)))
    else $error("length beyond store depth");

  // empty flag agrees with the reported length
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (empty_res == (length == '0)))
    else $error("empty flag disagrees with length");

endmodule

`default_nettype wire
